// ----- sv/gbc_pkg.sv -----
package gbc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_CRED   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_WAIT_VEHICLE = 3'd0,
    MODE_WAIT_CRED    = 3'd1,
    MODE_OPEN         = 3'd2,
    MODE_CLOSING      = 3'd3,
    MODE_WAIT_EXIT    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ARRIVED = 3'd1,
    EV_TIMEOUT = 3'd2,
    EV_GRANTED = 3'd3,
    EV_DENIED  = 3'd4,
    EV_CLOSING = 3'd5,
    EV_READY   = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    REG_DETECT_DISTANCE    = 3'd0,
    REG_LEAVE_DISTANCE     = 3'd1,
    REG_LEAVE_CONFIRM      = 3'd2,
    REG_CREDENTIAL_WAIT_MS = 3'd3,
    REG_GUARD_MS           = 3'd4,
    REG_SETTLE_MS          = 3'd5,
    REG_OPEN_LIMIT_MS      = 3'd6
  } reg_idx_e;

  localparam int unsigned DistW  = 16;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CountW = 3;
  localparam int unsigned IdW    = 10;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 16;

  localparam logic [DistW-1:0]  DetectDistanceRst   = 16'd300;
  localparam logic [DistW-1:0]  LeaveDistanceRst    = 16'd450;
  localparam logic [CountW-1:0] LeaveConfirmRst     = 3'd5;
  localparam logic [TimeW-1:0]  CredentialWaitMsRst = 16'd15000;
  localparam logic [TimeW-1:0]  GuardMsRst          = 16'd2000;
  localparam logic [TimeW-1:0]  SettleMsRst         = 16'd1000;
  localparam logic [TimeW-1:0]  OpenLimitMsRst      = 16'd8000;

  localparam logic [TimeW-1:0]  TicksMax = '1;
  localparam logic [CountW-1:0] FarMax   = '1;

  typedef struct packed {
    logic [DistW-1:0]  detect_distance;
    logic [DistW-1:0]  leave_distance;
    logic [CountW-1:0] leave_confirm;
    logic [TimeW-1:0]  credential_wait_ms;
    logic [TimeW-1:0]  guard_ms;
    logic [TimeW-1:0]  settle_ms;
    logic [TimeW-1:0]  open_limit_ms;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    event_e            ev;
    logic              gate_up;
    logic [DistW-1:0]  event_value;
    logic [CountW-1:0] leave_count;
  } res_t;

endpackage

// ----- sv/gbc_in_if.sv -----
interface gbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] distance_mm;
  logic        credential_ok;
  logic [9:0]  credential_id;

  modport source (output valid, command, distance_mm, credential_ok, credential_id,
                  input ready);
  modport sink (input valid, command, distance_mm, credential_ok, credential_id,
                output ready);
endinterface

// ----- sv/gbc_out_if.sv -----
interface gbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [2:0]  event_res;
  logic        gate_up;
  logic [15:0] event_value;
  logic [2:0]  leave_count;

  modport source (output valid, mode, event_res, gate_up, event_value, leave_count,
                  input ready);
  modport sink (input valid, mode, event_res, gate_up, event_value, leave_count,
                output ready);
endinterface

// ----- sv/gbc_cfg_if.sv -----
interface gbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/gbc_cfg_regs.sv -----
module gbc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [gbc_pkg::IdxW-1:0]      wr_idx_i,
  input  logic [gbc_pkg::DataW-1:0]     wr_data_i,
  output gbc_pkg::cfg_t                 cfg_o
);

  gbc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_distance    <= gbc_pkg::DetectDistanceRst;
      cfg_q.leave_distance     <= gbc_pkg::LeaveDistanceRst;
      cfg_q.leave_confirm      <= gbc_pkg::LeaveConfirmRst;
      cfg_q.credential_wait_ms <= gbc_pkg::CredentialWaitMsRst;
      cfg_q.guard_ms           <= gbc_pkg::GuardMsRst;
      cfg_q.settle_ms          <= gbc_pkg::SettleMsRst;
      cfg_q.open_limit_ms      <= gbc_pkg::OpenLimitMsRst;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        gbc_pkg::REG_DETECT_DISTANCE:    cfg_q.detect_distance    <= wr_data_i;
        gbc_pkg::REG_LEAVE_DISTANCE:     cfg_q.leave_distance     <= wr_data_i;
        gbc_pkg::REG_LEAVE_CONFIRM:
          cfg_q.leave_confirm <= wr_data_i[gbc_pkg::CountW-1:0];
        gbc_pkg::REG_CREDENTIAL_WAIT_MS: cfg_q.credential_wait_ms <= wr_data_i;
        gbc_pkg::REG_GUARD_MS:           cfg_q.guard_ms           <= wr_data_i;
        gbc_pkg::REG_SETTLE_MS:          cfg_q.settle_ms          <= wr_data_i;
        gbc_pkg::REG_OPEN_LIMIT_MS:      cfg_q.open_limit_ms      <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/gbc_core.sv -----
module gbc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbc_pkg::cfg_t                 cfg_i,
  input  logic                          accept_i,
  input  logic [1:0]                    command_i,
  input  logic [gbc_pkg::DistW-1:0]     distance_mm_i,
  input  logic                          credential_ok_i,
  input  logic [gbc_pkg::IdW-1:0]       credential_id_i,
  output gbc_pkg::res_t                 res_o
);

  gbc_pkg::mode_e              mode_q, mode_d;
  logic [gbc_pkg::TimeW-1:0]   ticks_q, ticks_d, ticks_inc;
  logic [gbc_pkg::CountW-1:0]  far_q, far_d, far_inc;
  logic                        open_q, open_d;
  logic                        cmd_known, is_tick, is_cred, sample, far_sample;
  logic                        cred_due, settle_due, arrive, confirm, open_leave;
  gbc_pkg::event_e             ev;
  logic [gbc_pkg::DistW-1:0]   value;

  always_comb begin
    is_tick    = (command_i == gbc_pkg::CMD_TICK);
    is_cred    = (command_i == gbc_pkg::CMD_CRED);
    cmd_known  = is_tick || is_cred || (command_i == gbc_pkg::CMD_SAMPLE);
    sample     = (command_i == gbc_pkg::CMD_SAMPLE) && (distance_mm_i != '0);
    ticks_inc  = (is_tick && ticks_q != gbc_pkg::TicksMax) ? ticks_q + 1'b1 : ticks_q;
    far_inc    = (far_q != gbc_pkg::FarMax) ? far_q + 1'b1 : far_q;
    far_sample = sample && (distance_mm_i > cfg_i.leave_distance);
    cred_due   = (ticks_inc >= cfg_i.credential_wait_ms);
    settle_due = (ticks_inc >= cfg_i.settle_ms);
    arrive     = sample && (distance_mm_i <= cfg_i.detect_distance);
    confirm    = far_sample && (far_inc >= cfg_i.leave_confirm);
    open_leave = sample && (ticks_inc >= cfg_i.guard_ms);
  end

  always_comb begin
    mode_d  = mode_q;
    ticks_d = ticks_q;
    far_d   = far_q;
    open_d  = open_q;
    if (cmd_known) begin
      ticks_d = ticks_inc;
      unique case (mode_q)
        gbc_pkg::MODE_WAIT_VEHICLE: begin
          if (arrive) begin
            ticks_d = '0;
            far_d   = '0;
            mode_d  = gbc_pkg::MODE_WAIT_CRED;
          end
        end
        gbc_pkg::MODE_WAIT_CRED: begin
          if (cred_due) begin
            far_d  = '0;
            mode_d = gbc_pkg::MODE_WAIT_EXIT;
          end else if (is_cred) begin
            far_d = '0;
            if (credential_ok_i) begin
              open_d  = 1'b1;
              ticks_d = '0;
              mode_d  = gbc_pkg::MODE_OPEN;
            end else begin
              mode_d = gbc_pkg::MODE_WAIT_EXIT;
            end
          end
        end
        gbc_pkg::MODE_OPEN: begin
          if (open_leave) begin
            far_d = '0;
            if (ticks_inc >= cfg_i.open_limit_ms) begin
              mode_d = gbc_pkg::MODE_WAIT_EXIT;
            end
          end
        end
        gbc_pkg::MODE_CLOSING: begin
          if (settle_due) begin
            mode_d = gbc_pkg::MODE_WAIT_VEHICLE;
          end
        end
        gbc_pkg::MODE_WAIT_EXIT: begin
          if (confirm) begin
            open_d  = 1'b0;
            ticks_d = '0;
            far_d   = '0;
            mode_d  = gbc_pkg::MODE_CLOSING;
          end else if (far_sample) begin
            far_d = far_inc;
          end else if (sample) begin
            far_d = '0;
          end
        end
        default: begin
          mode_d = gbc_pkg::MODE_WAIT_VEHICLE;
        end
      endcase
    end
  end

  always_comb begin
    ev    = gbc_pkg::EV_NONE;
    value = '0;
    if (cmd_known) begin
      unique case (mode_q)
        gbc_pkg::MODE_WAIT_VEHICLE: begin
          if (arrive) begin
            ev    = gbc_pkg::EV_ARRIVED;
            value = distance_mm_i;
          end
        end
        gbc_pkg::MODE_WAIT_CRED: begin
          if (cred_due) begin
            ev = gbc_pkg::EV_TIMEOUT;
          end else if (is_cred && credential_ok_i) begin
            ev    = gbc_pkg::EV_GRANTED;
            value = {{(gbc_pkg::DistW-gbc_pkg::IdW){1'b0}}, credential_id_i};
          end else if (is_cred) begin
            ev = gbc_pkg::EV_DENIED;
          end
        end
        gbc_pkg::MODE_CLOSING: begin
          if (settle_due) begin
            ev = gbc_pkg::EV_READY;
          end
        end
        gbc_pkg::MODE_WAIT_EXIT: begin
          if (confirm) begin
            ev = gbc_pkg::EV_CLOSING;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= gbc_pkg::MODE_WAIT_VEHICLE;
      ticks_q <= '0;
      far_q   <= '0;
      open_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      ticks_q <= ticks_d;
      far_q   <= far_d;
      open_q  <= open_d;
    end
  end

  assign res_o.mode         = mode_d;
  assign res_o.ev           = ev;
  assign res_o.gate_up      = open_d;
  assign res_o.event_value  = value;
  assign res_o.leave_count  = far_d;

endmodule

// ----- sv/gate_barrier_controller.sv -----
// Access-gate barrier controller.
// in_i carries one item per transfer: a 1 ms tick, a distance sample or a
// credential result, selected by command. out_o returns exactly one result
// per input item, in order: mode after the item, event code, barrier drive
// level, event value and the current far-sample count.
// cfg_i writes one of seven timing/threshold registers by index; it is
// always ready and is meant to be used only while no result is pending.
// Latency: the result of an item is presented on out_o in the cycle after
// its transfer. Throughput: one item per cycle while out_o is not stalled,
// set by the single result register behind the controller state update.
// When the receiver stalls, the result register holds its contents and
// in_i.ready stays high only if that register is drained in the same cycle.
// Reset puts the controller in the wait-vehicle mode with the barrier
// closed, counters cleared, registers at their defaults and no result held.
module gate_barrier_controller (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbc_in_if.sink    in_i,
  gbc_out_if.source out_o,
  gbc_cfg_if.sink   cfg_i
);

  gbc_pkg::cfg_t cfg;
  gbc_pkg::res_t res, res_q;
  logic          out_valid_q, accept;

  assign cfg_i.ready = 1'b1;

  gbc_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  gbc_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .accept_i        (accept),
    .command_i       (in_i.command),
    .distance_mm_i   (in_i.distance_mm),
    .credential_ok_i (in_i.credential_ok),
    .credential_id_i (in_i.credential_id),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mode         = res_q.mode;
  assign out_o.event_res    = res_q.ev;
  assign out_o.gate_up      = res_q.gate_up;
  assign out_o.event_value  = res_q.event_value;
  assign out_o.leave_count  = res_q.leave_count;

endmodule

// ----- sv/gbc_checker.sv -----
module gbc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_mode,
  input logic [2:0]  out_event,
  input logic        out_open,
  input logic [15:0] out_value
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_mode == gbc_pkg::MODE_WAIT_VEHICLE ||
                  out_mode == gbc_pkg::MODE_WAIT_CRED ||
                  out_mode == gbc_pkg::MODE_CLOSING) |-> !out_open)
    else $error("barrier open in a closed mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_event == gbc_pkg::EV_GRANTED |->
      out_mode == gbc_pkg::MODE_OPEN && out_open)
    else $error("grant without opening");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_event == gbc_pkg::EV_ARRIVED |->
      out_mode == gbc_pkg::MODE_WAIT_CRED && out_value != 16'd0)
    else $error("arrival with bad mode or distance");

endmodule

bind gate_barrier_controller gbc_sva u_gbc_sva (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_mode  (out_o.mode),
  .out_event (out_o.event_res),
  .out_open  (out_o.gate_up),
  .out_value (out_o.event_value)
);
